// ===== rtl/tkbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkbs_pkg: shared types and constants
// Payload structs, config codes and the half-precision ordering helpers.
// ----------------------------------------------------------------------------
package tkbs_pkg;

  localparam int MaxKeep = 64;
  localparam int KeepW = 7;
  localparam int SlotW = 6;
  localparam int GroupW = 13;
  localparam int PosW = 12;
  localparam logic [15:0] FillSmall = 16'h7bff;
  localparam logic [15:0] FillLarge = 16'hfbff;
  localparam logic [31:0] EmptyId = 32'hffffffff;

  localparam logic [1:0] CfgSelectSmallest = 2'd0;
  localparam logic [1:0] CfgKeepCount = 2'd1;
  localparam logic [1:0] CfgGroupSize = 2'd2;

  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] group_index;
    logic        last_in_query;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_distance;
    logic [31:0] out_id;
    logic        out_last;
  } out_req_t;

  typedef struct packed {
    logic [15:0] dval;
    logic [31:0] id;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic        fresh;
    logic [15:0] fill_dist;
    logic        sel_small;
    logic [16:0] key;
    entry_t      cand;
    logic        shift_out;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN
  } state_t;

  // ordered key: larger half value gives larger key
  function automatic logic [16:0] half_key(input logic [15:0] h);
    logic [16:0] k;
    if (h[15]) k = 17'h08000 - {2'b0, h[14:0]};
    else k = 17'h08000 + {2'b0, h[14:0]};
    return k;
  endfunction

  function automatic logic half_is_nan(input logic [15:0] h);
    return (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tkbs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkbs_cell: one slot of the sorted chain
// Holds one entry; takes the candidate or a neighbor's entry on insert,
// shifts toward the head on drain.
// ----------------------------------------------------------------------------
module tkbs_cell (
  input  wire logic                clk,
  input  wire tkbs_pkg::cell_ctl_t ctl,
  input  wire logic                insert,
  input  wire logic [16:0]         wkey,
  input  wire logic                active,
  input  wire tkbs_pkg::entry_t    prev_base,
  input  wire logic                prev_ge,
  input  wire logic                prev_eqw,
  input  wire tkbs_pkg::entry_t    next_base,
  input  wire tkbs_pkg::entry_t    next_e,
  input  wire logic                next_ge,
  input  wire logic                next_active,
  output tkbs_pkg::entry_t         e,
  output tkbs_pkg::entry_t         base,
  output logic [16:0]              key,
  output logic                     ge,
  output logic                     eqw
);

  tkbs_pkg::entry_t e_r, e_nxt;

  // a closed query reads as the fill entry
  always_comb begin
    base = e_r;
    if (ctl.fresh) begin
      base.dval = ctl.fill_dist;
      base.id = tkbs_pkg::EmptyId;
    end
    key = tkbs_pkg::half_key(base.dval);
    ge = (key >= ctl.key);
    eqw = active && (key == wkey);
  end

  always_comb begin
    e_nxt = base;
    if (ctl.shift_out) begin
      e_nxt = next_e;
    end else if (insert && active) begin
      if (ctl.sel_small) begin
        // head dropped: cells move up until the insertion point
        if (next_active && next_ge) e_nxt = next_base;
        else if (ge) e_nxt = ctl.cand;
      end else if (!ge) begin
        // first cell of the worst run dropped: cells move down up to it
        if (prev_ge) e_nxt = ctl.cand;
        else if (!(eqw && prev_eqw)) e_nxt = prev_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  assign e = e_r;

endmodule
`default_nettype wire

// ===== rtl/topk_bucket_select_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle except while results drain; the chain of slots
// updates in the cycle the item is accepted
// the last item is followed by keep_count results (clamped) drained from the
// head of the chain, starting the cycle after it, input is stalled meanwhile
// reset: synchronous active low, registers go to select_smallest 1,
// keep_count 16, group_size 16, query closed
// ----------------------------------------------------------------------------
// topk_bucket_select_top: streaming top-k selection
// Insertion chain of MaxKeep slots kept in descending order, drained on the
// last item of each query.
// ----------------------------------------------------------------------------
module topk_bucket_select_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tkbs_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tkbs_pkg::out_req_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  localparam int N = tkbs_pkg::MaxKeep;

  // configuration registers
  logic                        sel_small_r;
  logic [tkbs_pkg::KeepW-1:0]  keep_r;
  logic [tkbs_pkg::GroupW-1:0] group_r;

  // per-query latched values
  logic                        q_small_r;
  logic [tkbs_pkg::KeepW-1:0]  q_keep_r;
  logic [tkbs_pkg::GroupW-1:0] q_group_r;
  logic                        open_r;
  logic [tkbs_pkg::PosW-1:0]   pos_r;

  tkbs_pkg::state_t            state_r, state_nxt;
  logic [tkbs_pkg::KeepW-1:0]  cnt_r;

  logic in_acc, out_acc;
  logic [tkbs_pkg::KeepW-1:0]  k_eff;
  logic [tkbs_pkg::GroupW-1:0] g_eff;
  logic                        cur_small;
  logic [tkbs_pkg::KeepW-1:0]  cur_keep;
  logic [tkbs_pkg::GroupW-1:0] cur_group;
  logic [tkbs_pkg::PosW-1:0]   cur_pos;
  logic [15:0]                 fill_d;
  logic [16:0]                 ck;
  logic                        nan;
  logic [31:0]                 cid;
  logic [28:0]                 prod;
  logic [tkbs_pkg::PosW:0]     pos_inc;

  // chain signals, index 0 holds the largest value (emitted first)
  tkbs_pkg::cell_ctl_t         ctl;
  tkbs_pkg::entry_t            e_w [N];
  tkbs_pkg::entry_t            base_w [N];
  logic [16:0]                 key_w [N];
  logic [N-1:0]                ge_w;
  logic [N-1:0]                eqw_w;
  logic [N-1:0]                inr;
  logic [tkbs_pkg::SlotW-1:0]  last_idx;
  logic [16:0]                 wkey;
  logic                        better;
  logic                        insert;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r == tkbs_pkg::ST_DRAIN);
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_small_r <= 1'b1;
      keep_r <= 7'd16;
      group_r <= 13'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        tkbs_pkg::CfgSelectSmallest: sel_small_r <= cfg_data[0];
        tkbs_pkg::CfgKeepCount:      keep_r <= cfg_data[6:0];
        tkbs_pkg::CfgGroupSize:      group_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamp registers at query start
  always_comb begin
    k_eff = keep_r;
    if (keep_r == '0) k_eff = 7'd1;
    if (keep_r > 7'(N)) k_eff = 7'(N);
    g_eff = group_r;
    if (group_r == '0) g_eff = 13'd1;
    if (group_r > 13'd4096) g_eff = 13'd4096;
  end

  // a new query uses freshly latched values and a refilled chain
  assign cur_small = open_r ? q_small_r : sel_small_r;
  assign cur_keep  = open_r ? q_keep_r  : k_eff;
  assign cur_group = open_r ? q_group_r : g_eff;
  assign cur_pos   = open_r ? pos_r : '0;
  assign fill_d    = cur_small ? tkbs_pkg::FillSmall : tkbs_pkg::FillLarge;

  // id: group_index * group_size + position, 16x13 multiply
  assign prod = 29'(in_data.group_index) * 29'(cur_group);
  assign cid  = {3'b0, prod} + {20'b0, cur_pos};
  assign ck   = tkbs_pkg::half_key(in_data.distance);
  assign nan  = tkbs_pkg::half_is_nan(in_data.distance);
  assign pos_inc = {1'b0, cur_pos} + 1'b1;

  // slots below keep_count take part in the query
  always_comb begin
    for (int i = 0; i < N; i++) inr[i] = (7'(i) < cur_keep);
  end

  // worst entry: head in smallest mode, last kept slot in largest mode
  // (keep of 64 wraps the index to 63)
  assign last_idx = cur_keep[tkbs_pkg::SlotW-1:0] - 6'd1;
  assign wkey = cur_small ? key_w[0] : key_w[last_idx];
  assign better = !nan && (cur_small ? (ck < wkey) : (ck > wkey));
  assign insert = in_acc && better;

  // broadcast to the chain; the fill view only while idle between queries
  always_comb begin
    ctl.fresh = !open_r && (state_r == tkbs_pkg::ST_RUN);
    ctl.fill_dist = fill_d;
    ctl.sel_small = cur_small;
    ctl.key = ck;
    ctl.cand.dval = in_data.distance;
    ctl.cand.id = cid;
    ctl.shift_out = (state_r == tkbs_pkg::ST_DRAIN) && out_acc;
  end

  // chain of cells, each talking only to its two neighbors
  // ties: earlier arrival sits at the lower index
  for (genvar i = 0; i < N; i++) begin : g_cell
    tkbs_pkg::entry_t p_base, n_base, n_e;
    logic             p_ge, p_eqw, n_ge, n_act;

    if (i == 0) begin : g_head
      assign p_base = '0;
      assign p_ge = 1'b1;
      assign p_eqw = 1'b0;
    end else begin : g_prev
      assign p_base = base_w[i-1];
      assign p_ge = ge_w[i-1];
      assign p_eqw = eqw_w[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign n_base = '0;
      assign n_e = '0;
      assign n_ge = 1'b0;
      assign n_act = 1'b0;
    end else begin : g_next
      assign n_base = base_w[i+1];
      assign n_e = e_w[i+1];
      assign n_ge = ge_w[i+1];
      assign n_act = inr[i+1];
    end

    tkbs_cell u_cell (
      .clk(clk), .ctl(ctl), .insert(insert), .wkey(wkey), .active(inr[i]),
      .prev_base(p_base), .prev_ge(p_ge), .prev_eqw(p_eqw),
      .next_base(n_base), .next_e(n_e), .next_ge(n_ge), .next_active(n_act),
      .e(e_w[i]), .base(base_w[i]), .key(key_w[i]), .ge(ge_w[i]),
      .eqw(eqw_w[i])
    );
  end

  // query control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkbs_pkg::ST_RUN:   if (in_acc && in_data.last_in_query) state_nxt = tkbs_pkg::ST_DRAIN;
      tkbs_pkg::ST_DRAIN: if (out_acc && cnt_r == 7'd1) state_nxt = tkbs_pkg::ST_RUN;
      default: state_nxt = tkbs_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkbs_pkg::ST_RUN;
      open_r <= 1'b0;
      pos_r <= '0;
      cnt_r <= '0;
      q_small_r <= 1'b1;
      q_keep_r <= 7'd16;
      q_group_r <= 13'd16;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        q_small_r <= cur_small;
        q_keep_r <= cur_keep;
        q_group_r <= cur_group;
        open_r <= !in_data.last_in_query;
        pos_r <= (14'(pos_inc) >= 14'(cur_group)) ? '0 : pos_inc[tkbs_pkg::PosW-1:0];
        cnt_r <= cur_keep;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  assign out_valid = (state_r == tkbs_pkg::ST_DRAIN);
  assign out_data.out_distance = e_w[0].dval;
  assign out_data.out_id = e_w[0].id;
  assign out_data.out_last = (cnt_r == 7'd1);

endmodule
`default_nettype wire
